// ===== src/ir_cse_emit_table_core_assert.svh =====
// Assertion macros for the chain table block and its port checker.
// Depends on nothing; the using scope must provide i_clk and i_rst_n.
`ifndef IR_CSE_EMIT_TABLE_CORE_ASSERT_SVH
`define IR_CSE_EMIT_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IRCSE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IRCSE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ircse_pkg.sv =====
// Shared types and constants of the instruction chain table.
// Used by the sequencer and the top level; depends on nothing.
package ircse_pkg;

    localparam int REF_BIAS_DEF    = 32768;
    localparam int MAX_ENTRIES_DEF = 4096;
    localparam int OP_COUNT_DEF    = 64;

    localparam int REF_W  = 16;
    localparam int OPC_W  = 6;
    localparam int VT_W   = 4;
    localparam int MASK_W = 64;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 2;

    // References at or above this value are never handed out.
    localparam logic [REF_W:0] REF_CEILING = 17'h0fff0;

    typedef struct packed {
        logic [REF_W-1:0] prev;
        logic [VT_W-1:0]  vtype;
        logic [REF_W-1:0] opb;
        logic [REF_W-1:0] opa;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic             ovf;
        logic             reused;
        logic [REF_W-1:0] rref;
    } t_result;

endpackage

// ===== src/ircse_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module ircse_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/ircse_seq.sv =====
// Sequencer of the chain table: walks one opcode chain through S_CHECK and S_ENTRY.
// Depends on ircse_pkg; drives the head and entry RAMs in the top level.
module ircse_seq #(
    parameter  int REF_BIAS    = ircse_pkg::REF_BIAS_DEF,
    parameter  int MAX_ENTRIES = ircse_pkg::MAX_ENTRIES_DEF,
    parameter  int OP_COUNT    = ircse_pkg::OP_COUNT_DEF,
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int OPA_W       = (OP_COUNT > 1) ? $clog2(OP_COUNT) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_req_type,
    input  logic [ircse_pkg::OPC_W-1:0]   i_opcode,
    input  logic [ircse_pkg::VT_W-1:0]    i_vtype,
    input  logic [ircse_pkg::REF_W-1:0]   i_opa,
    input  logic [ircse_pkg::REF_W-1:0]   i_opb,
    input  logic [ircse_pkg::MASK_W-1:0]  i_mask,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ircse_pkg::t_result            o_result,
    output logic                          o_head_we,
    output logic [OPA_W-1:0]              o_head_waddr,
    output logic [ircse_pkg::REF_W-1:0]   o_head_wdata,
    output logic [OPA_W-1:0]              o_head_raddr,
    input  logic [ircse_pkg::REF_W-1:0]   i_head_rdata,
    output logic                          o_ent_we,
    output logic [IDX_W-1:0]              o_ent_waddr,
    output ircse_pkg::t_entry             o_ent_wdata,
    output logic [IDX_W-1:0]              o_ent_raddr,
    input  ircse_pkg::t_entry             i_ent_rdata
);
    import ircse_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_CHECK,
        S_ENTRY,
        S_APPEND,
        S_FINISH
    } t_state;

    t_state             r_state;
    logic [OPC_W-1:0]   r_opc;
    logic [VT_W-1:0]    r_vt;
    logic [REF_W-1:0]   r_opa;
    logic [REF_W-1:0]   r_opb;
    logic [REF_W-1:0]   r_ref;
    logic [REF_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_count;
    logic [OP_COUNT-1:0] r_head_vld;
    t_result            r_res;
    t_result            r_out;
    logic               r_out_valid;

    logic [OPA_W-1:0]   op_idx;
    logic [REF_W-1:0]   head_rd;
    logic [REF_W-1:0]   limit;
    logic [REF_W-1:0]   ent_off;
    logic               walk_go;
    logic               match;
    logic [REF_W:0]     ref_sum;
    logic               full;

    assign op_idx  = r_opc[OPA_W-1:0];
    // A chain head that was never written since reset or clear reads as empty.
    assign head_rd = r_head_vld[op_idx] ? i_head_rdata : '0;
    assign limit   = (r_opa > r_opb) ? r_opa : r_opb;
    assign ent_off = r_ref - REF_W'(REF_BIAS);

    // A link ends the walk when it is empty, not newer than both operands,
    // or does not name an entry written since the last clear.
    assign walk_go = (r_ref != '0) && (r_ref > limit) && (r_ref >= REF_W'(REF_BIAS)) &&
                     ({1'b0, ent_off} < (REF_W + 1)'(r_count));

    assign match = (i_ent_rdata.opa == r_opa) && (i_ent_rdata.opb == r_opb) &&
                   (i_ent_rdata.vtype == r_vt);

    assign ref_sum = (REF_W + 1)'(REF_BIAS) + (REF_W + 1)'(r_count);
    assign full    = (ref_sum >= REF_CEILING) || (r_count >= CNT_W'(MAX_ENTRIES));

    assign o_head_raddr = i_opcode[OPA_W-1:0];
    assign o_head_we    = (r_state == S_APPEND) && !full;
    assign o_head_waddr = op_idx;
    assign o_head_wdata = ref_sum[REF_W-1:0];

    assign o_ent_raddr  = ent_off[IDX_W-1:0];
    assign o_ent_we     = (r_state == S_APPEND) && !full;
    assign o_ent_waddr  = r_count[IDX_W-1:0];
    assign o_ent_wdata  = '{prev: r_head, vtype: r_vt, opb: r_opb, opa: r_opa};

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A taken result drops the valid flag unless the next one loads now.
            if (r_out_valid && i_out_ready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_opc <= i_opcode;
                        r_vt  <= i_vtype;
                        r_opa <= i_opa;
                        r_opb <= i_opb;
                        if (i_req_type) begin
                            r_count    <= '0;
                            r_head_vld <= '0;
                            r_res      <= '0;
                            r_state    <= S_FINISH;
                        end else if ((OPC_W + 1)'(i_opcode) >= (OPC_W + 1)'(OP_COUNT)) begin
                            r_res   <= '0;
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_HEAD;
                        end
                    end
                end
                S_HEAD: begin
                    r_head  <= head_rd;
                    r_ref   <= i_mask[r_opc] ? '0 : head_rd;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_state <= walk_go ? S_ENTRY : S_APPEND;
                end
                S_ENTRY: begin
                    if (match) begin
                        r_res   <= '{ovf: 1'b0, reused: 1'b1, rref: r_ref};
                        r_state <= S_FINISH;
                    end else begin
                        r_ref   <= i_ent_rdata.prev;
                        r_state <= S_CHECK;
                    end
                end
                S_APPEND: begin
                    if (full) begin
                        r_res <= '{ovf: 1'b1, reused: 1'b0, rref: '0};
                    end else begin
                        r_count            <= CNT_W'(r_count + 1'b1);
                        r_head_vld[op_idx] <= 1'b1;
                        r_res <= '{ovf: 1'b0, reused: 1'b0, rref: ref_sum[REF_W-1:0]};
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/ir_cse_emit_table_core.sv =====
// Top level of the instruction chain table with common-subexpression reuse.
// Depends on ircse_pkg, ircse_seq and ircse_ram.
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  one request per transfer
//  m_axis    out        m_axis_tvalid / m_axis_tready  one result per request
//  cfg       in         i_cfg_wr_en                    impure opcode mask
//
// A clear request or an opcode at or beyond OP_COUNT goes from S_IDLE straight to S_FINISH.
// An emit reads its chain head in S_HEAD, then visits entries in S_CHECK and S_ENTRY;
// a match goes on to S_FINISH, a miss through S_APPEND; the entry RAM read per visited
// link (one read, one compare) sets the pace of the walk.
// Reset and clear only drop the per-opcode head valid bits and the entry count,
// so no clearing pass runs. A stalled result holds its register; the next
// request may still be accepted and is worked on until its own result is ready.
module ir_cse_emit_table_core #(
    parameter int REF_BIAS    = ircse_pkg::REF_BIAS_DEF,
    parameter int MAX_ENTRIES = ircse_pkg::MAX_ENTRIES_DEF,
    parameter int OP_COUNT    = ircse_pkg::OP_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [ircse_pkg::MASK_W-1:0]      i_cfg_wr_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: opcode[5:0], value_type[9:6], operand_a[25:10], operand_b[41:26], zero fill
    input  logic [ircse_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: req_type[0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: result_ref[15:0]
    output logic [ircse_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // tuser: reused[0], overflow[1]
    output logic [ircse_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
    import ircse_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OPA_W = (OP_COUNT > 1) ? $clog2(OP_COUNT) : 1;

    // Impure opcode mask: a set bit keeps that opcode out of the chain walk,
    // while its chain is still extended on every append.
    logic [MASK_W-1:0] r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cfg_wr_en) begin
            r_mask <= i_cfg_wr_data;
        end
    end

    // Unpack the request fields from the slave-side transfer.
    logic [OPC_W-1:0] req_opc;
    logic [VT_W-1:0]  req_vt;
    logic [REF_W-1:0] req_opa;
    logic [REF_W-1:0] req_opb;

    assign req_opc = s_axis_tdata[5:0];
    assign req_vt  = s_axis_tdata[9:6];
    assign req_opa = s_axis_tdata[25:10];
    assign req_opb = s_axis_tdata[41:26];

    logic             head_we;
    logic [OPA_W-1:0] head_waddr;
    logic [REF_W-1:0] head_wdata;
    logic [OPA_W-1:0] head_raddr;
    logic [REF_W-1:0] head_rdata;
    logic             ent_we;
    logic [IDX_W-1:0] ent_waddr;
    t_entry           ent_wdata;
    logic [IDX_W-1:0] ent_raddr;
    t_entry           ent_rdata;
    t_result          result;

    // The sequencer owns all control: the walk pointer, the entry count,
    // the head valid bits and the output register.
    ircse_seq #(
        .REF_BIAS    (REF_BIAS),
        .MAX_ENTRIES (MAX_ENTRIES),
        .OP_COUNT    (OP_COUNT)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_req_type   (s_axis_tuser),
        .i_opcode     (req_opc),
        .i_vtype      (req_vt),
        .i_opa        (req_opa),
        .i_opb        (req_opb),
        .i_mask       (r_mask),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_result     (result),
        .o_head_we    (head_we),
        .o_head_waddr (head_waddr),
        .o_head_wdata (head_wdata),
        .o_head_raddr (head_raddr),
        .i_head_rdata (head_rdata),
        .o_ent_we     (ent_we),
        .o_ent_waddr  (ent_waddr),
        .o_ent_wdata  (ent_wdata),
        .o_ent_raddr  (ent_raddr),
        .i_ent_rdata  (ent_rdata)
    );

    // One chain head per opcode, newest reference of that opcode.
    ircse_ram #(
        .WIDTH (REF_W),
        .DEPTH (OP_COUNT)
    ) u_head_ram (
        .i_clk     (i_clk),
        .i_wr_en   (head_we),
        .i_wr_addr (head_waddr),
        .i_wr_data (head_wdata),
        .i_rd_addr (head_raddr),
        .o_rd_data (head_rdata)
    );

    // The append-only store: operands, type and the link to the previous
    // entry of the same opcode, all in one word per entry.
    ircse_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ent_we),
        .i_wr_addr (ent_waddr),
        .i_wr_data (ent_wdata),
        .i_rd_addr (ent_raddr),
        .o_rd_data (ent_rdata)
    );

    assign m_axis_tdata = result.rref;
    assign m_axis_tuser = {result.ovf, result.reused};

endmodule

// ===== src/ircse_chk.sv =====
// Port-level checker for the chain table top level, bound to it below.
// Depends on ir_cse_emit_table_core_assert.svh.
`include "ir_cse_emit_table_core_assert.svh"

module ircse_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A waiting result stays offered until it is taken.
    `IRCSE_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

    // The block works on one request at a time.
    `IRCSE_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after an accepted request")

    // Overflow carries no reference and no reuse.
    `IRCSE_ASSERT_IMP(a_ovf_clean, m_axis_tvalid && m_axis_tuser[1], (m_axis_tdata == 16'd0) && !m_axis_tuser[0], "overflow result with reference or reuse")

    // A reused entry always has a real reference.
    `IRCSE_ASSERT_IMP(a_reuse_ref, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata != 16'd0, "reused result with empty reference")

endmodule

bind ir_cse_emit_table_core ircse_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the instruction chain table with subexpression reuse.
// Depends on ircse_pkg and ir_cse_emit_table_core, with its ircse_seq and ircse_ram.
// The predictor here mirrors the table so that each result is checked field by field.
module tb;

    import ircse_pkg::*;

    localparam int          BIAS        = REF_BIAS_DEF;
    localparam int          MAXE        = MAX_ENTRIES_DEF;
    localparam int          OPS         = OP_COUNT_DEF;
    localparam int          CFG_SETTLE  = 4;
    localparam int          TAIL_CYCLES = 20;
    localparam int          HOLD_CYCLES = 300;
    localparam int          HISTORY_MAX = 512;
    localparam int          PHASE_ITEMS = 175;
    localparam int          PRINT_MAX   = 50;
    localparam logic [63:0] MASK_NONE   = 64'h0;
    localparam logic [63:0] MASK_ALL    = 64'hFFFF_FFFF_FFFF_FFFF;

    // Request kinds as carried on s_axis_tuser.
    typedef enum logic {
        REQ_EMIT  = 1'b0,
        REQ_CLEAR = 1'b1
    } t_req_kind;

    typedef enum logic {
        ROW_REQUEST  = 1'b0,
        ROW_SET_MASK = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_req_kind        kind;
        logic [OPC_W-1:0] opcode;
        logic [VT_W-1:0]  vt;
        logic [REF_W-1:0] opa;
        logic [REF_W-1:0] opb;
    } t_cse_req;

    // One row of the directed table: either a request or a new impure mask.
    // Where typed is set, want holds the result read straight off the chain rules.
    typedef struct packed {
        t_row_kind        kind;
        t_cse_req         rq;
        logic [MASK_W-1:0] mask;
        logic             typed;
        t_result          want;
    } t_dir_row;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [MASK_W-1:0]      i_cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [OUT_USER_W-1:0]  m_axis_tuser;

    // Predictor state: the entry store, the opcode chain heads, the fill count
    // and the impure opcode mask as the block should hold them.
    t_entry             tbl_store [MAXE];
    logic [REF_W-1:0]   tbl_head  [OPS] = '{default: '0};
    int unsigned        tbl_count = 0;
    logic [MASK_W-1:0]  tbl_mask  = '0;

    // Results the block still owes, oldest first.
    t_result            owed_results [$];
    // Up to HISTORY_MAX emits since the last clear, for replays that should hit.
    t_cse_req           live_emits [$];
    t_dir_row           dir_rows [$];

    int unsigned        bad_results = 0;
    int unsigned        burst_left  = 0;

    // Receiver pacing. The main thread bumps hold_tokens to ask for a long
    // hold-off; the receiver counts the hold itself.
    int unsigned        hold_tokens = 0;
    int unsigned        holds_taken = 0;
    int unsigned        hold_left   = 0;
    int unsigned        stall_pct   = 0;
    int unsigned        pace_cycle  = 0;

    always #1 i_clk = ~i_clk;

    ir_cse_emit_table_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Walks the chain of a pure opcode for a matching entry and appends on a miss.
    // A clear empties the chains; a full store answers with the overflow flag.
    function automatic t_result cse_lookup_or_append(input t_cse_req rq);
        t_result     res;
        int unsigned limit;
        int unsigned r;
        int unsigned idx;
        int unsigned steps;
        res = '0;
        if (rq.kind == REQ_CLEAR) begin
            tbl_count = 0;
            foreach (tbl_head[i]) tbl_head[i] = '0;
            return res;
        end
        if (int'(rq.opcode) >= OPS) return res;
        limit = (rq.opa > rq.opb) ? rq.opa : rq.opb;
        if (!tbl_mask[rq.opcode]) begin
            r = tbl_head[rq.opcode];
            steps = 0;
            // The walk stops at the first entry not newer than both operands.
            while (r != 0 && r > limit && steps < MAXE) begin
                if (r < BIAS) break;
                idx = r - BIAS;
                if (idx >= tbl_count || idx >= MAXE) break;
                if (tbl_store[idx].opa == rq.opa && tbl_store[idx].opb == rq.opb &&
                    tbl_store[idx].vtype == rq.vt) begin
                    res.rref   = REF_W'(r);
                    res.reused = 1'b1;
                    return res;
                end
                r = tbl_store[idx].prev;
                steps++;
            end
        end
        if (tbl_count + BIAS >= int'(REF_CEILING) || tbl_count >= MAXE) begin
            res.ovf = 1'b1;
            return res;
        end
        idx = tbl_count;
        tbl_store[idx].opa   = rq.opa;
        tbl_store[idx].opb   = rq.opb;
        tbl_store[idx].vtype = rq.vt;
        tbl_store[idx].prev  = tbl_head[rq.opcode];
        tbl_head[rq.opcode]  = REF_W'(BIAS + idx);
        tbl_count            = idx + 1;
        res.rref             = REF_W'(BIAS + idx);
        return res;
    endfunction

    function automatic void add_request(input t_req_kind k, input logic [OPC_W-1:0] op,
                                        input logic [VT_W-1:0] vt,
                                        input logic [REF_W-1:0] a, input logic [REF_W-1:0] b,
                                        input logic typed, input logic [REF_W-1:0] rref,
                                        input logic reused, input logic ovf);
        t_dir_row row;
        row             = '0;
        row.kind        = ROW_REQUEST;
        row.rq.kind     = k;
        row.rq.opcode   = op;
        row.rq.vt       = vt;
        row.rq.opa      = a;
        row.rq.opb      = b;
        row.typed       = typed;
        row.want.rref   = rref;
        row.want.reused = reused;
        row.want.ovf    = ovf;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void add_mask(input logic [MASK_W-1:0] v);
        t_dir_row row;
        row      = '0;
        row.kind = ROW_SET_MASK;
        row.mask = v;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // An operand the way a compiler would form it: none, a small constant,
    // or a reference to an instruction already in the store.
    function automatic logic [REF_W-1:0] pick_operand();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) return '0;
        if (sel < 4 || tbl_count == 0) return REF_W'($urandom_range(1, BIAS - 1));
        return REF_W'(BIAS + $urandom_range(0, tbl_count - 1));
    endfunction

    // Mostly replays and well-formed emits so that chains get walked and hit,
    // with some clears and fully random requests mixed in.
    function automatic t_cse_req draw_request();
        t_cse_req    rq;
        int unsigned pick;
        pick      = $urandom_range(0, 99);
        rq.kind   = REQ_EMIT;
        rq.opcode = OPC_W'($urandom_range(0, OPS - 1));
        rq.vt     = VT_W'($urandom_range(0, 15));
        rq.opa    = REF_W'($urandom);
        rq.opb    = REF_W'($urandom);
        if (pick < 2) begin
            rq.kind = REQ_CLEAR;
        end else if (pick < 50 && live_emits.size() != 0) begin
            rq = live_emits[$urandom_range(0, live_emits.size() - 1)];
            // Now and then turn the replay into a near miss.
            case ($urandom_range(0, 7))
                0: rq.vt  = rq.vt ^ VT_W'($urandom_range(1, 15));
                1: rq.opb = pick_operand();
                default: ;
            endcase
        end else if (pick < 87) begin
            rq.opcode = OPC_W'($urandom_range(0, 7));
            rq.opa    = pick_operand();
            rq.opb    = pick_operand();
        end
        return rq;
    endfunction

    // Offers one request in the current burst and books its result once
    // the transfer has happened. Gaps between bursts are random.
    task automatic push_request(input t_cse_req rq, input logic typed, input t_result want);
        t_result pred;
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tdata  <= {{(IN_DATA_W - 42){1'b0}}, rq.opb, rq.opa, rq.vt, rq.opcode};
        s_axis_tuser  <= rq.kind;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        pred = cse_lookup_or_append(rq);
        owed_results.insert(owed_results.size(), typed ? want : pred);
        if (rq.kind == REQ_CLEAR) begin
            live_emits.delete();
        end else begin
            live_emits.insert(live_emits.size(), rq);
            if (live_emits.size() > HISTORY_MAX) void'(live_emits.pop_front());
        end
    endtask

    // The sender stops and waits until every owed result has been taken.
    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (owed_results.size() != 0);
    endtask

    // The mask is only rewritten while the block is idle.
    task automatic retune_mask(input logic [MASK_W-1:0] v);
        wait_all_results();
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tbl_mask = v;
    endtask

    // Receiver: checks every result transfer against the oldest owed result
    // and paces tready. The stall rate is redrawn by pace_cycle, and a hold
    // request keeps tready low for a long stretch.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.rref   = m_axis_tdata;
            got.reused = m_axis_tuser[0];
            got.ovf    = m_axis_tuser[1];
            if (owed_results.size() == 0) begin
                if (bad_results < PRINT_MAX)
                    $display({"%0t unexpected result: expected none, ",
                              "actual ref %h reused %b overflow %b"},
                             $time, got.rref, got.reused, got.ovf);
                bad_results++;
            end else begin
                want = owed_results.pop_front();
                if (got.rref !== want.rref) begin
                    if (bad_results < PRINT_MAX)
                        $display("%0t result_ref mismatch: expected %h, actual %h",
                                 $time, want.rref, got.rref);
                    bad_results++;
                end
                if (got.reused !== want.reused) begin
                    if (bad_results < PRINT_MAX)
                        $display("%0t reused mismatch: expected %b, actual %b",
                                 $time, want.reused, got.reused);
                    bad_results++;
                end
                if (got.ovf !== want.ovf) begin
                    if (bad_results < PRINT_MAX)
                        $display("%0t overflow mismatch: expected %b, actual %b",
                                 $time, want.ovf, got.ovf);
                    bad_results++;
                end
            end
        end
        pace_cycle++;
        if (pace_cycle % 64 == 0) begin
            case ($urandom_range(0, 4))
                0, 1: stall_pct = 0;
                2:    stall_pct = 25;
                3:    stall_pct = 50;
                default: stall_pct = 90;
            endcase
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_tokens != holds_taken) begin
            holds_taken++;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin
        t_cse_req    rq;
        logic [MASK_W-1:0] phase_mask;

        // Directed table. Typed rows follow straight from the chain rules:
        // the first emit lands at the bias, an identical emit is reused, a
        // different type or swapped operands append, operands at the top of
        // the range block the walk, a clear restarts at the bias and an
        // impure opcode never shares.
        add_mask(MASK_NONE);
        add_request(REQ_EMIT,  6'd0,  4'd0,  16'h0000, 16'h0000, 1'b1, 16'h8000, 1'b0, 1'b0);
        add_request(REQ_EMIT,  6'd0,  4'd0,  16'h0000, 16'h0000, 1'b1, 16'h8000, 1'b1, 1'b0);
        add_request(REQ_EMIT,  6'd0,  4'd1,  16'h0000, 16'h0000, 1'b1, 16'h8001, 1'b0, 1'b0);
        add_request(REQ_EMIT,  6'd0,  4'd15, 16'h0000, 16'h0000, 1'b1, 16'h8002, 1'b0, 1'b0);
        add_request(REQ_EMIT,  6'd63, 4'd0,  16'h0000, 16'h0000, 1'b1, 16'h8003, 1'b0, 1'b0);
        add_request(REQ_EMIT,  6'd63, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1, 16'h8004, 1'b0, 1'b0);
        add_request(REQ_EMIT,  6'd63, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1, 16'h8005, 1'b0, 1'b0);
        add_request(REQ_EMIT,  6'd0,  4'd0,  16'h0000, 16'h0000, 1'b1, 16'h8000, 1'b1, 1'b0);
        add_request(REQ_EMIT,  6'd5,  4'd3,  16'h8000, 16'h8003, 1'b1, 16'h8006, 1'b0, 1'b0);
        add_request(REQ_EMIT,  6'd5,  4'd3,  16'h8003, 16'h8000, 1'b1, 16'h8007, 1'b0, 1'b0);
        add_request(REQ_EMIT,  6'd5,  4'd3,  16'h8000, 16'h8003, 1'b1, 16'h8006, 1'b1, 1'b0);
        // The walk stops at 0x8006, not newer than operand a, so this appends.
        add_request(REQ_EMIT,  6'd5,  4'd3,  16'h8006, 16'h0000, 1'b1, 16'h8008, 1'b0, 1'b0);
        add_request(REQ_EMIT,  6'd5,  4'd3,  16'h8006, 16'h0000, 1'b1, 16'h8008, 1'b1, 1'b0);
        add_request(REQ_EMIT,  6'd42, 4'd10, 16'hAAAA, 16'h5555, 1'b0, '0, 1'b0, 1'b0);
        add_request(REQ_EMIT,  6'd21, 4'd5,  16'h5555, 16'hAAAA, 1'b0, '0, 1'b0, 1'b0);
        add_request(REQ_CLEAR, 6'd63, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, 1'b0, 1'b0);
        add_request(REQ_EMIT,  6'd0,  4'd0,  16'h0000, 16'h0000, 1'b1, 16'h8000, 1'b0, 1'b0);
        add_request(REQ_EMIT,  6'd0,  4'd0,  16'h0000, 16'h0000, 1'b1, 16'h8000, 1'b1, 1'b0);
        add_mask(MASK_ALL);
        add_request(REQ_EMIT,  6'd0,  4'd0,  16'h0000, 16'h0000, 1'b1, 16'h8001, 1'b0, 1'b0);
        add_request(REQ_EMIT,  6'd0,  4'd0,  16'h0000, 16'h0000, 1'b1, 16'h8002, 1'b0, 1'b0);
        add_mask(64'h8000_0000_0000_0001);
        add_request(REQ_EMIT,  6'd63, 4'd0,  16'h0000, 16'h0000, 1'b1, 16'h8003, 1'b0, 1'b0);
        add_request(REQ_EMIT,  6'd1,  4'd0,  16'h0000, 16'h0000, 1'b1, 16'h8004, 1'b0, 1'b0);
        add_request(REQ_EMIT,  6'd1,  4'd0,  16'h0000, 16'h0000, 1'b1, 16'h8004, 1'b1, 1'b0);
        add_request(REQ_CLEAR, 6'd0,  4'd0,  16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_SET_MASK)
                retune_mask(dir_rows[i].mask);
            else
                push_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random phases, each under its own mask. The second phase starts
        // with a long receiver hold-off so the block backs up into its input;
        // in the third the sender pauses midway until all results are in.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       phase_mask = {$urandom, $urandom};
                1:       phase_mask = MASK_NONE;
                2:       phase_mask = 64'hFFFF_FFFF_0000_0000;
                default: phase_mask = {$urandom, $urandom};
            endcase
            retune_mask(phase_mask);
            rq = '0;
            rq.kind = REQ_CLEAR;
            push_request(rq, 1'b0, '0);
            if (phase == 1) hold_tokens++;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 2 && n == PHASE_ITEMS / 2) wait_all_results();
                push_request(draw_request(), 1'b0, '0);
            end
        end

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (bad_results == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== ir_cse_emit_table_core.f =====
+incdir+src
src/ircse_pkg.sv
src/ircse_ram.sv
src/ircse_seq.sv
src/ir_cse_emit_table_core.sv
src/ircse_chk.sv
tb/tb.sv
